// File: src/u8dec_pkg.sv
// Package for the UTF-8 stream decoder: result kinds, widths and the
// result and decode structs shared by the decoder, the queue and the top level.
// No dependencies.
package u8dec_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CpW        = 31;
  localparam int unsigned RemW       = 3;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    KIND_CP  = 2'd0,
    KIND_END = 2'd1,
    KIND_BAD = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    kind_e          kind;
    logic           last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } dec_out_t;

endpackage

// File: src/u8dec_if.sv
// Valid/ready channel interfaces of the UTF-8 stream decoder: raw bytes in,
// decoded results out. Depends on u8dec_pkg.
interface u8dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

interface u8dec_res_if;
  logic               valid;
  logic               ready;
  logic [30:0]        code_point;
  u8dec_pkg::kind_e   kind;
  logic               last;

  modport source (output valid, output code_point, output kind, output last, input ready);
  modport sink   (input valid, input code_point, input kind, input last, output ready);
endinterface

// File: src/u8dec_dec.sv
// Byte decoder of the UTF-8 stream decoder: sequence state and the per-byte
// logic that yields zero, one or two results. Depends on u8dec_pkg.
module u8dec_dec (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    byte_value_i,
  output u8dec_pkg::dec_out_t           dec_o
);
  import u8dec_pkg::*;

  logic [RemW-1:0] rem_q, rem_d;
  logic [CpW-1:0]  acc_q, acc_d;

  logic            s_emit;
  res_t            s_res;
  logic [RemW-1:0] s_rem;
  logic [CpW-1:0]  s_acc;
  logic [CpW-1:0]  acc_shift;

  // decode the byte as if no sequence were open
  always_comb begin
    s_emit = 1'b0;
    s_res  = '{code_point: '0, kind: KIND_BAD, last: 1'b1};
    s_rem  = '0;
    s_acc  = '0;
    unique case (byte_value_i) inside
      8'h00: begin
        s_emit      = 1'b1;
        s_res.kind  = KIND_END;
      end
      [8'h01:8'h7F]: begin
        s_emit           = 1'b1;
        s_res.kind       = KIND_CP;
        s_res.code_point = CpW'(byte_value_i);
      end
      [8'h80:8'hBF], 8'hFE, 8'hFF: begin
        s_emit     = 1'b1;
        s_res.kind = KIND_BAD;
      end
      [8'hC0:8'hDF]: begin
        s_rem = RemW'(1);
        s_acc = CpW'(byte_value_i[4:0]);
      end
      [8'hE0:8'hEF]: begin
        s_rem = RemW'(2);
        s_acc = CpW'(byte_value_i[3:0]);
      end
      [8'hF0:8'hF7]: begin
        s_rem = RemW'(3);
        s_acc = CpW'(byte_value_i[2:0]);
      end
      [8'hF8:8'hFB]: begin
        s_rem = RemW'(4);
        s_acc = CpW'(byte_value_i[1:0]);
      end
      [8'hFC:8'hFD]: begin
        s_rem = RemW'(5);
        s_acc = CpW'(byte_value_i[0]);
      end
      default: begin
        s_emit     = 1'b1;
        s_res.kind = KIND_BAD;
      end
    endcase
  end

  assign acc_shift = {acc_q[CpW-7:0], byte_value_i[5:0]};

  always_comb begin
    dec_o  = '{num: 2'd0,
               first: '{code_point: '0, kind: KIND_BAD, last: 1'b1},
               second: '{code_point: '0, kind: KIND_BAD, last: 1'b1}};
    rem_d  = rem_q;
    acc_d  = acc_q;
    if (accept_i) begin
      if (rem_q == '0) begin
        dec_o.num   = {1'b0, s_emit};
        dec_o.first = s_res;
        rem_d       = s_rem;
        acc_d       = s_acc;
      end else if (byte_value_i[7:6] == 2'b10) begin
        rem_d = rem_q - RemW'(1);
        if (rem_q == RemW'(1)) begin
          dec_o.num   = 2'd1;
          dec_o.first = '{code_point: acc_shift, kind: KIND_CP, last: 1'b1};
          acc_d       = '0;
        end else begin
          acc_d = acc_shift;
        end
      end else begin
        // cut short: flag it, then restart on this byte
        dec_o.first.last = ~s_emit;
        dec_o.second     = s_res;
        dec_o.num        = s_emit ? 2'd2 : 2'd1;
        rem_d            = s_rem;
        acc_d            = s_acc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      acc_q <= '0;
    end else begin
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

endmodule

// File: src/u8dec_rq.sv
// Result queue of the UTF-8 stream decoder: takes up to two results a cycle,
// hands one a cycle to the output while it is ready. Depends on u8dec_pkg.
module u8dec_rq #(
  parameter int unsigned Depth = u8dec_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  u8dec_pkg::dec_out_t           push_i,
  input  logic                          pop_i,
  output u8dec_pkg::res_t               head_o,
  output logic                          head_valid_o,
  output logic                          room_o,
  output logic [$clog2(Depth+1)-1:0]    level_o
);
  import u8dec_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_nx;
  logic [CntW-1:0] level_q, level_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  assign wptr_nx      = ptr_inc(wptr_q);
  assign head_o       = mem_q[rptr_q];
  assign head_valid_o = (level_q != '0);
  assign room_o       = (level_q <= RoomMax);
  assign level_o      = level_q;

  always_comb begin
    case (push_i.num)
      2'd1:    wptr_d = wptr_nx;
      2'd2:    wptr_d = ptr_inc(wptr_nx);
      default: wptr_d = wptr_q;
    endcase
    rptr_d  = pop_i ? ptr_inc(rptr_q) : rptr_q;
    level_d = level_q + CntW'(push_i.num) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wptr_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

endmodule

// File: src/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder (1 to 6 byte sequences, 31-bit code points).
// Depends on u8dec_pkg, u8dec_if, u8dec_dec and u8dec_rq.
//
// in_byte carries one raw byte per item; out_res carries one result per item:
// code_point, kind (code point, end marker for a zero byte, invalid) and last,
// which marks the final result that one byte caused. Both use valid/ready.
// A byte is decoded in the cycle it is accepted and its results are written to
// the result queue, behind those held; out_res.valid is high in the next cycle.
// Lead and middle continuation bytes give no result, a cut-short sequence gives
// an invalid result followed by the result, if any, of the breaking byte.
// Throughput: one byte per cycle while in_byte.ready is high; out_res moves one
// result per cycle while the receiver is ready, so each result of a byte is its
// own transfer. in_byte.ready is high while the queue has room for two results
// (Depth - 2 or fewer held), so a stalled receiver holds the queue and, once it
// fills, holds in_byte. Reset clears the open sequence, the accumulator and the
// queue; nothing is lost or repeated across stalls on either side.
module utf8_stream_decoder #(
  parameter int unsigned QDepth = u8dec_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  u8dec_byte_if.sink    in_byte,
  u8dec_res_if.source   out_res
);
  import u8dec_pkg::*;

  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic            accept;
  logic            pop;
  logic            room;
  logic            head_valid;
  logic [CntW-1:0] level;
  dec_out_t        dec_out;
  res_t            head;

  assign accept = in_byte.valid & in_byte.ready;
  assign pop    = out_res.valid & out_res.ready;

  u8dec_dec u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_value_i (in_byte.byte_value),
    .dec_o        (dec_out)
  );

  u8dec_rq #(
    .Depth (QDepth)
  ) u_rq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (dec_out),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .room_o       (room),
    .level_o      (level)
  );

  assign in_byte.ready      = room;
  assign out_res.valid      = head_valid;
  assign out_res.code_point = head.code_point;
  assign out_res.kind       = head.kind;
  assign out_res.last       = head.last;

  a_two_results_bad_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_out.num == 2'd2 |-> dec_out.first.kind == KIND_BAD && !dec_out.first.last
                            && dec_out.second.last)
    else $error("two results without a leading invalid");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && dec_out.num != 2'd0 |=> out_res.valid)
    else $error("decoded result not presented");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= CntW'(QDepth))
    else $error("result queue overflow");

  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid && out_res.kind != KIND_CP |-> out_res.code_point == '0)
    else $error("nonzero code point on a marker");

endmodule

// File: test/tb_utf8_stream_decoder.sv
// Testbench for utf8_stream_decoder: directed and random byte streams with random
// idling on both channels, checked against a behavioral decoder kept in this file.
// Depends on u8dec_pkg, u8dec_if and the decoder RTL.
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import u8dec_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned LongHold    = 80;
  localparam int unsigned RandomItems = 1000;
  localparam int unsigned MaxPrints   = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  u8dec_byte_if byte_ch ();
  u8dec_res_if  res_ch ();

  utf8_stream_decoder DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_byte (byte_ch),
    .out_res (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [2:0]  rem_bytes = '0;
  logic [30:0] cp_accum  = '0;
  res_t        step_res[$];
  res_t        due_results[$];

  int unsigned err_cnt   = 0;
  int unsigned idle_cnt  = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_left = 0;
  bit          tx_gaps   = 1'b0;
  bit          rx_stalls = 1'b0;

  task automatic report(input string msg);
    if (err_cnt < MaxPrints) $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 7) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic void open_or_emit(input logic [7:0] b);
    res_t r;
    r.code_point = '0;
    r.kind       = KIND_BAD;
    r.last       = 1'b0;
    if (b == 8'h00) begin
      r.kind = KIND_END;
      step_res.push_back(r);
    end else if (!b[7]) begin
      r.kind       = KIND_CP;
      r.code_point = {23'd0, b};
      step_res.push_back(r);
    end else if (b[7:6] == 2'b10 || b >= 8'hFE) begin
      step_res.push_back(r);
    end else if (b[7:5] == 3'b110) begin
      rem_bytes = 3'd1;
      cp_accum  = {26'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      rem_bytes = 3'd2;
      cp_accum  = {27'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      rem_bytes = 3'd3;
      cp_accum  = {28'd0, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      rem_bytes = 3'd4;
      cp_accum  = {29'd0, b[1:0]};
    end else begin
      rem_bytes = 3'd5;
      cp_accum  = {30'd0, b[0]};
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    res_t r;
    step_res.delete();
    r.code_point = '0;
    r.kind       = KIND_BAD;
    r.last       = 1'b0;
    if (rem_bytes == 3'd0) begin
      open_or_emit(b);
    end else if (b[7:6] == 2'b10) begin
      cp_accum  = {cp_accum[24:0], b[5:0]};
      rem_bytes = rem_bytes - 3'd1;
      if (rem_bytes == 3'd0) begin
        r.kind       = KIND_CP;
        r.code_point = cp_accum;
        step_res.push_back(r);
        cp_accum = '0;
      end
    end else begin
      step_res.push_back(r);
      rem_bytes = '0;
      cp_accum  = '0;
      open_or_emit(b);
    end
    if (step_res.size() > 0) begin
      r      = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
    foreach (step_res[i]) due_results.push_back(step_res[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.byte_value <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    decode_byte(b);
  endtask

  task automatic send_list(input logic [7:0] list[$]);
    foreach (list[i]) send_byte(list[i]);
  endtask

  task automatic send_seq(input int unsigned len, input int unsigned n_cont);
    logic [7:0] r8;
    r8 = 8'($urandom);
    case (len)
      1:       send_byte({1'b0, r8[6:0]});
      2:       send_byte({3'b110, r8[4:0]});
      3:       send_byte({4'b1110, r8[3:0]});
      4:       send_byte({5'b11110, r8[2:0]});
      5:       send_byte({6'b111110, r8[1:0]});
      default: send_byte({7'b1111110, r8[0]});
    endcase
    repeat (n_cont) send_byte({2'b10, 6'($urandom)});
  endtask

  // Receiver: random stalls, plus one long hold on request.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if (rx_stalls && $urandom_range(0, 3) == 0) hold_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result cp=%h kind=%0d last=%b",
                         res_ch.code_point, res_ch.kind, res_ch.last));
      end else begin
        exp_r = due_results.pop_front();
        if (res_ch.code_point !== exp_r.code_point || res_ch.kind !== exp_r.kind ||
            res_ch.last !== exp_r.last)
          report($sformatf("got cp=%h kind=%0d last=%b, want cp=%h kind=%0d last=%b",
                           res_ch.code_point, res_ch.kind, res_ch.last,
                           exp_r.code_point, exp_r.kind, exp_r.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IdleLimit) begin
        $display("utf8_stream_decoder: mismatch");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  task automatic test_ascii_and_sequences();
    send_list('{8'h00, 8'h7F, 8'h41,
                8'hC0, 8'h80,
                8'hE2, 8'h82, 8'hAC,
                8'hF0, 8'h9F, 8'h98, 8'h80,
                8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF});
  endtask

  task automatic test_invalid_bytes();
    send_list('{8'h80, 8'hBF, 8'hFE, 8'hFF,
                8'hE2, 8'h41,
                8'hC2, 8'h00,
                8'hF0, 8'h80, 8'hFF,
                8'hC2, 8'hE2, 8'h82, 8'hAC});
  endtask

  task automatic test_output_stall();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_req  = LongHold;
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) send_list('{8'h30 + 8'(i), 8'hC2, 8'h5A});
  endtask

  task automatic test_random_stream(input int unsigned n_items);
    int unsigned sent;
    int unsigned next_mode;
    int unsigned len;
    int unsigned n_cont;
    int unsigned pick;
    sent      = 0;
    next_mode = 0;
    while (sent < n_items) begin
      if (sent >= next_mode) begin
        pick      = $urandom_range(0, 3);
        tx_gaps   = pick[0];
        rx_stalls = pick[1];
        next_mode = sent + $urandom_range(50, 150);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len    = $urandom_range(1, 6);
        n_cont = len - 1;
        send_seq(len, n_cont);
      end else if (pick < 82) begin
        len    = $urandom_range(2, 6);
        n_cont = $urandom_range(0, len - 2);
        send_seq(len, n_cont);
      end else begin
        n_cont = 0;
        send_byte(8'($urandom));
      end
      sent += 1 + n_cont;
    end
  endtask

  initial begin
    byte_ch.valid      = 1'b0;
    byte_ch.byte_value = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ascii_and_sequences();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    test_invalid_bytes();
    test_output_stall();
    test_random_stream(RandomItems);

    byte_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (due_results.size() != 0) report("results still outstanding at end of run");

    if (err_cnt == 0) $display("utf8_stream_decoder: match");
    else $display("utf8_stream_decoder: mismatch");
    $finish;
  end

endmodule
